// ===== rtl/core/ssw_pkg.sv =====
// ----------------------------------------------------------------------------
// Shell sort package
// Shared constants, control word layout and the microprogram of the sorter.
// ----------------------------------------------------------------------------
package ssw_pkg;

    localparam int DATA_W           = 32;
    localparam int MAX_ELEMENTS_DEF = 64;

    // Division of the gap by three: (gap * 171) >> 9 is exact below 256.
    localparam int RECIP3           = 171;
    localparam int RECIP3_W         = 8;
    localparam int RECIP3_SHIFT     = 9;

    localparam int PC_W             = 4;

    // Step addresses of the microprogram.
    localparam logic [PC_W-1:0] ST_LOAD  = 4'd0;
    localparam logic [PC_W-1:0] ST_GINIT = 4'd1;
    localparam logic [PC_W-1:0] ST_GUP   = 4'd2;
    localparam logic [PC_W-1:0] ST_GDOWN = 4'd3;
    localparam logic [PC_W-1:0] ST_ICHK  = 4'd4;
    localparam logic [PC_W-1:0] ST_VLOAD = 4'd5;
    localparam logic [PC_W-1:0] ST_JCHK  = 4'd6;
    localparam logic [PC_W-1:0] ST_CMP   = 4'd7;
    localparam logic [PC_W-1:0] ST_WRV   = 4'd8;
    localparam logic [PC_W-1:0] ST_PEND  = 4'd9;
    localparam logic [PC_W-1:0] ST_ESET  = 4'd10;
    localparam logic [PC_W-1:0] ST_ERD   = 4'd11;
    localparam logic [PC_W-1:0] ST_EOUT  = 4'd12;
    localparam logic [PC_W-1:0] ST_CLR   = 4'd13;
    localparam logic [PC_W-1:0] ST_SHIFT = 4'd14;

    typedef enum logic [1:0] {RD_NONE, RD_I, RD_JG, RD_K} t_rd_sel;
    typedef enum logic [1:0] {WR_NONE, WR_SHIFT, WR_V} t_wr_sel;
    typedef enum logic [1:0] {G_HOLD, G_ONE, G_UP, G_DOWN} t_gap_op;
    typedef enum logic [1:0] {I_HOLD, I_GAP, I_INC} t_i_op;
    typedef enum logic [1:0] {J_HOLD, J_I, J_DEC} t_j_op;
    typedef enum logic [1:0] {K_HOLD, K_ZERO, K_INC} t_k_op;
    typedef enum logic [1:0] {W_NONE, W_IN, W_OUT} t_wait;
    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NOT_LAST,
        C_UP_LE_N,
        C_I_GE_N,
        C_J_LT_GAP,
        C_GREATER,
        C_GAP_GT1,
        C_NOT_K_LAST
    } t_cond;

    typedef struct packed {
        t_wait           wait_on;
        logic            in_load;
        logic            load_v;
        logic            out_load;
        logic            clr;
        t_rd_sel         rd_sel;
        t_wr_sel         wr_sel;
        t_gap_op         gap_op;
        t_i_op           i_op;
        t_j_op           j_op;
        t_k_op           k_op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ctrl;

    localparam t_ctrl CTRL_NOP = '{
        wait_on: W_NONE, in_load: 1'b0, load_v: 1'b0, out_load: 1'b0, clr: 1'b0,
        rd_sel: RD_NONE, wr_sel: WR_NONE, gap_op: G_HOLD, i_op: I_HOLD,
        j_op: J_HOLD, k_op: K_HOLD, cond: C_NONE, target: ST_LOAD
    };

    // Microprogram: a taken condition jumps to target, otherwise the next step.
    function automatic t_ctrl rom_word(logic [PC_W-1:0] pc);
        t_ctrl cw;
        cw = CTRL_NOP;
        unique case (pc)
            ST_LOAD: begin
                cw.wait_on = W_IN;
                cw.in_load = 1'b1;
                cw.cond    = C_NOT_LAST;
                cw.target  = ST_LOAD;
            end
            ST_GINIT: begin
                cw.gap_op = G_ONE;
            end
            ST_GUP: begin
                cw.gap_op = G_UP;
                cw.cond   = C_UP_LE_N;
                cw.target = ST_GUP;
            end
            ST_GDOWN: begin
                cw.gap_op = G_DOWN;
                cw.i_op   = I_GAP;
            end
            ST_ICHK: begin
                cw.rd_sel = RD_I;
                cw.j_op   = J_I;
                cw.cond   = C_I_GE_N;
                cw.target = ST_PEND;
            end
            ST_VLOAD: begin
                cw.load_v = 1'b1;
            end
            ST_JCHK: begin
                cw.rd_sel = RD_JG;
                cw.cond   = C_J_LT_GAP;
                cw.target = ST_WRV;
            end
            ST_CMP: begin
                cw.cond   = C_GREATER;
                cw.target = ST_SHIFT;
            end
            ST_WRV: begin
                cw.wr_sel = WR_V;
                cw.i_op   = I_INC;
                cw.cond   = C_ALWAYS;
                cw.target = ST_ICHK;
            end
            ST_PEND: begin
                cw.cond   = C_GAP_GT1;
                cw.target = ST_GDOWN;
            end
            ST_ESET: begin
                cw.k_op = K_ZERO;
            end
            ST_ERD: begin
                cw.wait_on = W_OUT;
                cw.rd_sel  = RD_K;
            end
            ST_EOUT: begin
                cw.out_load = 1'b1;
                cw.k_op     = K_INC;
                cw.cond     = C_NOT_K_LAST;
                cw.target   = ST_ERD;
            end
            ST_CLR: begin
                cw.clr    = 1'b1;
                cw.cond   = C_ALWAYS;
                cw.target = ST_LOAD;
            end
            ST_SHIFT: begin
                cw.wr_sel = WR_SHIFT;
                cw.j_op   = J_DEC;
                cw.cond   = C_ALWAYS;
                cw.target = ST_JCHK;
            end
            default: begin
                cw.cond   = C_ALWAYS;
                cw.target = ST_LOAD;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== rtl/core/shell_sort_signed_words_top.sv =====
// ----------------------------------------------------------------------------
// Shell sort of signed words
// Collects a set of signed words, sorts it in place and streams it out.
// ----------------------------------------------------------------------------
// Words arrive one per transfer and are written to a store of MAX_ELEMENTS
// entries; the transfer marked last closes the set. Words load back to
// back. The set is then sorted with Shell sort (gaps 1, 4, 13, 40, ...)
// by a small microprogram that executes one control word per cycle, except
// while a step waits on a transfer, against a single store with one read
// and one write port: the starting gap is found by stepping up the gap
// sequence past the word count and back one step, and each insertion shifts
// the greater words a gap below its word up before writing the word back.
// The sorted words then leave one by one while the receiver keeps up, the last
// marked final, and the count is then cleared. Words beyond the capacity are
// dropped and every result of that set then carries the overflow flag. A new
// set may be loaded while the last result still waits in the output register.
module shell_sort_signed_words_top
    import ssw_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [DATA_W-1:0] i_word_value,
    input  logic                     i_is_last,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_is_final,
    output logic                     o_overflow
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int GW = $clog2(3 * MAX_ELEMENTS + 2);

    logic [PC_W-1:0]   r_pc, n_pc;
    logic [CW-1:0]     r_n, n_n;
    logic              r_drop, n_drop;
    logic [GW-1:0]     r_gap, n_gap;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_j, n_j;
    logic [AW-1:0]     r_k, n_k;
    logic [DATA_W-1:0] r_v, n_v;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_value;
    logic              r_out_final;
    logic              r_out_ovf;

    t_ctrl             cw;
    logic              in_xfer;
    logic              out_free;
    logic              go;
    logic              cond_hit;
    logic              k_last;
    logic [GW+1:0]     gap_up;
    logic [GW+RECIP3_W-1:0] gap_prod;
    logic [GW-1:0]     gap_div;
    logic [AW-1:0]     jg_addr;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    assign cw       = rom_word(r_pc);
    assign o_ready  = (cw.wait_on == W_IN);
    assign in_xfer  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        unique case (cw.wait_on)
            W_IN:    go = in_xfer;
            W_OUT:   go = out_free;
            default: go = 1'b1;
        endcase
    end

    assign gap_up   = (GW + 2)'(r_gap) * (GW + 2)'(3) + (GW + 2)'(1);
    assign gap_prod = (GW + RECIP3_W)'(r_gap) * (GW + RECIP3_W)'(RECIP3);
    assign gap_div  = GW'(gap_prod >> RECIP3_SHIFT);
    assign jg_addr  = AW'(r_j - CW'(r_gap));
    assign k_last   = ((CW'(r_k) + CW'(1)) == r_n);

    always_comb begin
        unique case (cw.cond)
            C_ALWAYS:     cond_hit = 1'b1;
            C_NOT_LAST:   cond_hit = !i_is_last;
            C_UP_LE_N:    cond_hit = (gap_up <= (GW + 2)'(r_n));
            C_I_GE_N:     cond_hit = (r_i >= r_n);
            C_J_LT_GAP:   cond_hit = (GW'(r_j) < r_gap);
            C_GREATER:    cond_hit = ($signed(ram_rdata) > $signed(r_v));
            C_GAP_GT1:    cond_hit = (r_gap > GW'(1));
            C_NOT_K_LAST: cond_hit = !k_last;
            default:      cond_hit = 1'b0;
        endcase
    end

    // Step counter and datapath registers.
    always_comb begin
        n_pc        = r_pc;
        n_n         = r_n;
        n_drop      = r_drop;
        n_gap       = r_gap;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_v         = r_v;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        if (go) begin
            n_pc = cond_hit ? cw.target : r_pc + PC_W'(1);

            if (cw.in_load) begin
                if (r_n < CW'(MAX_ELEMENTS)) begin
                    n_n = r_n + CW'(1);
                end else begin
                    n_drop = 1'b1;
                end
            end
            if (cw.clr) begin
                n_n    = '0;
                n_drop = 1'b0;
            end
            if (cw.load_v) begin
                n_v = ram_rdata;
            end
            if (cw.out_load) begin
                n_out_valid = 1'b1;
            end

            case (cw.gap_op)
                G_ONE:   n_gap = GW'(1);
                G_UP:    n_gap = GW'(gap_up);
                G_DOWN:  n_gap = gap_div;
                default: n_gap = r_gap;
            endcase
            case (cw.i_op)
                I_GAP:   n_i = CW'(gap_div);
                I_INC:   n_i = r_i + CW'(1);
                default: n_i = r_i;
            endcase
            case (cw.j_op)
                J_I:     n_j = r_i;
                J_DEC:   n_j = r_j - CW'(r_gap);
                default: n_j = r_j;
            endcase
            case (cw.k_op)
                K_ZERO:  n_k = '0;
                K_INC:   n_k = r_k + AW'(1);
                default: n_k = r_k;
            endcase
        end
    end

    // Store ports.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_j[AW-1:0];
        ram_wdata = r_v;
        if (go && cw.in_load) begin
            ram_we    = (r_n < CW'(MAX_ELEMENTS));
            ram_waddr = r_n[AW-1:0];
            ram_wdata = i_word_value;
        end else if (go) begin
            case (cw.wr_sel)
                WR_SHIFT: begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                end
                WR_V:     ram_we = 1'b1;
                default:  ram_we = 1'b0;
            endcase
        end

        ram_re = go && (cw.rd_sel != RD_NONE);
        case (cw.rd_sel)
            RD_I:    ram_raddr = r_i[AW-1:0];
            RD_JG:   ram_raddr = jg_addr;
            RD_K:    ram_raddr = r_k;
            default: ram_raddr = r_k;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= ST_LOAD;
            r_n         <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_n         <= n_n;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gap <= n_gap;
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
        r_v   <= n_v;
        if (go && cw.out_load) begin
            r_out_value <= ram_rdata;
            r_out_final <= k_last;
            r_out_ovf   <= r_drop;
        end
    end

    ssw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_valid        = r_out_valid;
    assign o_sorted_value = $signed(r_out_value);
    assign o_is_final     = r_out_final;
    assign o_overflow     = r_out_ovf;

endmodule

// ===== rtl/core/ssw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/shell_sort_signed_words_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shell sort of signed words: testbench
// Sends sets of signed words with valid/ready on both sides. Each set is
// sorted by a model in the bench, and every transfer that leaves the block is
// compared with the oldest word still due. A short table of hand-picked sets
// comes first, then an overfull set, then sets of random size and content
// with random idling.
// ----------------------------------------------------------------------------
module shell_sort_signed_words_top_tb
    import ssw_pkg::*;
();

    localparam int CAPACITY      = MAX_ELEMENTS_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_WORDS  = 30;
    localparam int TABLE_ROWS    = 20;

    typedef logic signed [DATA_W-1:0] t_word;

    typedef struct packed {
        t_word value;
        logic  is_final;
        logic  overflow;
    } t_sorted_word;

    // A row with a typed answer closes a set of one word.
    typedef struct packed {
        t_word value;
        logic  is_last;
        logic  typed;
        t_word want_value;
        logic  want_overflow;
    } t_stim_row;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_ready;
    t_word i_word_value = '0;
    logic  i_is_last = 1'b0;
    logic  o_valid;
    logic  i_ready = 1'b0;
    t_word o_sorted_value;
    logic  o_is_final;
    logic  o_overflow;

    // Sorting model: its own copy of the store and the words still due out.
    t_word        held_words [CAPACITY];
    int           held_count = 0;
    logic         held_dropped = 1'b0;
    t_sorted_word words_due [$];

    int   mismatches = 0;
    int   results_seen = 0;
    int   cycles = 0;
    int   burst_left = 0;
    logic hold_req = 1'b0;

    t_stim_row table_rows [TABLE_ROWS] = '{
        '{32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000, 1'b0},
        '{32'sh7fff_ffff, 1'b1, 1'b1, 32'sh7fff_ffff, 1'b0},
        '{32'sh0000_0000, 1'b1, 1'b1, 32'sh0000_0000, 1'b0},
        '{-32'sd1,        1'b1, 1'b1, -32'sd1,        1'b0},
        '{32'sh7fff_ffff, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{32'sh8000_0000, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{32'sh0000_0000, 1'b0, 1'b0, 32'sh0,         1'b0},
        '{-32'sd1,        1'b0, 1'b0, 32'sh0,         1'b0},
        '{32'sd5,         1'b0, 1'b0, 32'sh0,         1'b0},
        '{32'sd5,         1'b0, 1'b0, 32'sh0,         1'b0},
        '{-32'sd5,        1'b0, 1'b0, 32'sh0,         1'b0},
        '{32'sd1,         1'b1, 1'b0, 32'sh0,         1'b0},
        '{32'sd1,         1'b0, 1'b0, 32'sh0,         1'b0},
        '{32'sd2,         1'b1, 1'b0, 32'sh0,         1'b0},
        '{32'sd6,         1'b0, 1'b0, 32'sh0,         1'b0},
        '{32'sd4,         1'b0, 1'b0, 32'sh0,         1'b0},
        '{32'sd2,         1'b0, 1'b0, 32'sh0,         1'b0},
        '{32'sd0,         1'b0, 1'b0, 32'sh0,         1'b0},
        '{-32'sd2,        1'b0, 1'b0, 32'sh0,         1'b0},
        '{-32'sd4,        1'b1, 1'b0, 32'sh0,         1'b0}
    };

    shell_sort_signed_words_top #(
        .MAX_ELEMENTS(CAPACITY)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_word_value  (i_word_value),
        .i_is_last     (i_is_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_sorted_value(o_sorted_value),
        .o_is_final    (o_is_final),
        .o_overflow    (o_overflow)
    );

    always #1 i_clk = ~i_clk;

    // Stores one accepted word; the closing word sorts the set and, when
    // asked, queues the sorted words with their flags.
    function automatic void absorb_word(input t_word w, input logic last, input logic emit);
        t_word pick;
        int    j;
        if (held_count < CAPACITY) begin
            held_words[held_count] = w;
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (!last)
            return;
        for (int i = 1; i < held_count; i++) begin
            pick = held_words[i];
            j = i;
            while (j > 0 && held_words[j-1] > pick) begin
                held_words[j] = held_words[j-1];
                j--;
            end
            held_words[j] = pick;
        end
        if (emit) begin
            for (int k = 0; k < held_count; k++)
                words_due.push_back('{held_words[k], k == held_count - 1, held_dropped});
        end
        held_count = 0;
        held_dropped = 1'b0;
    endfunction

    // Extremes and a narrow band around zero turn up often, so that equal
    // words and the sign boundary are well exercised.
    function automatic t_word pick_word();
        t_word w;
        case ($urandom_range(0, 7))
            0:       w = 32'sh8000_0000;
            1:       w = 32'sh7fff_ffff;
            2, 3:    w = int'($urandom_range(0, 8)) - 4;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic send_word(input t_word w, input logic last, input logic emit);
        int gap;
        i_valid      <= 1'b1;
        i_word_value <= w;
        i_is_last    <= last;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        absorb_word(w, last, emit);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_set(input int size);
        for (int k = 0; k < size; k++)
            send_word(pick_word(), k == size - 1, 1'b1);
    endtask

    task automatic wait_all_sorted();
        i_valid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        mismatches++;
        $display("mismatch on %s at result %0d: got %h, expected %h",
                 what, results_seen, got, want);
    endtask

    // Receiver: the stall pattern is redrawn at random after each phase of random
    // length; a request for a long hold-off keeps ready low while the sender carries on.
    initial begin : receiver
        int mode;
        int phase_left;
        mode = 0;
        phase_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (phase_left == 0) begin
                mode = $urandom_range(0, 3);
                phase_left = $urandom_range(10, 60);
            end
            phase_left--;
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                case (mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= ($urandom_range(0, 3) != 0);
                    2:       i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= ~i_ready;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_sorted_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (words_due.size() == 0) begin
                report_mismatch("unexpected result", o_sorted_value, '0);
            end else begin
                want = words_due.pop_front();
                if (o_sorted_value !== want.value)
                    report_mismatch("sorted_value", o_sorted_value, want.value);
                if (o_is_final !== want.is_final)
                    report_mismatch("is_final", t_word'(o_is_final), t_word'(want.is_final));
                if (o_overflow !== want.overflow)
                    report_mismatch("overflow", t_word'(o_overflow), t_word'(want.overflow));
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due", cycles, words_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int random_words;
        int set_index;
        int size;
        random_words = 0;
        set_index = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Typed answers are queued ahead of the transfer, since a set of one
        // word may come back before the sender's gap is over.
        foreach (table_rows[r]) begin
            if (table_rows[r].typed) begin
                words_due.push_back('{table_rows[r].want_value, 1'b1,
                                      table_rows[r].want_overflow});
                send_word(table_rows[r].value, table_rows[r].is_last, 1'b0);
            end else begin
                send_word(table_rows[r].value, table_rows[r].is_last, 1'b1);
            end
        end
        wait_all_sorted();

        // A set that fills the store and whose last words, the closing one
        // among them, find no room.
        send_set(CAPACITY + $urandom_range(1, 3));

        while (random_words < RANDOM_WORDS) begin
            if (set_index == 1)
                hold_req = 1'b1;
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
            send_set(size);
            random_words += size;
            set_index++;
        end

        wait_all_sorted();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ssw_pkg.sv
rtl/core/ssw_ram.sv
rtl/core/shell_sort_signed_words_top.sv
tb/shell_sort_signed_words_top_tb.sv
